FILE: hdl/rbst_pkg.sv
// ----------------------------------------------------------------------------
// rbst_pkg: shared types and constants for the ray/box slab test
// Holds field widths, configuration register indexes and inter-module structs.
// ----------------------------------------------------------------------------
package rbst_pkg;

  localparam int COORD_W  = 32;
  localparam int CFG_W    = 17;
  localparam int NUM_W    = 33;   // corner minus origin
  localparam int DIV_W    = 49;   // numerator magnitude after shift by 16
  localparam int QUO_W    = 49;
  localparam int NUM_AXES = 3;
  localparam int IDX_W    = 1;

  localparam logic [IDX_W-1:0] REG_ZERO_TOL = 1'd0;
  localparam logic [IDX_W-1:0] REG_MIN_T    = 1'd1;

  localparam logic signed [COORD_W-1:0] T_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] T_MIN = 32'sh8000_0000;

  // Per-lane result handed to the merge stage.
  typedef struct packed {
    logic                      par;   // direction counts as zero
    logic                      out;   // origin outside slab (parallel case)
    logic signed [COORD_W-1:0] t_lo;  // ordered slab distances
    logic signed [COORD_W-1:0] t_hi;
  } lane_res_t;

endpackage

FILE: hdl/rbst_div.sv
// ----------------------------------------------------------------------------
// rbst_div: pipelined unsigned restoring divider
// One quotient bit per stage; accepts a new operand pair every cycle while en is high.
// ----------------------------------------------------------------------------
module rbst_div import rbst_pkg::*; #(
  parameter int NW = DIV_W,
  parameter int DW = COORD_W,
  parameter int TW = 4
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag_in,
  output logic [NW-1:0] quo,
  output logic [TW-1:0] tag_out
);

  logic [NW-1:0] n_r   [1:NW];
  logic [TW-1:0] t_r   [1:NW];
  logic [DW:0]   rem_r [1:NW-1];
  logic [DW-1:0] d_r   [1:NW-1];

  // Each stage shifts one numerator bit into the remainder and subtracts.
  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [NW-1:0] n_in;
    logic [DW:0]   rem_in;
    logic [DW-1:0] d_in;
    logic [TW-1:0] t_in;
    logic [DW+1:0] sh;
    logic [DW+1:0] df;
    logic [NW-1:0] n_nxt;

    // The first stage takes the operands, the others the previous stage.
    if (s == 0) begin : g_first
      assign n_in   = num;
      assign rem_in = '0;
      assign d_in   = den;
      assign t_in   = tag_in;
    end else begin : g_next
      assign n_in   = n_r[s];
      assign rem_in = rem_r[s];
      assign d_in   = d_r[s];
      assign t_in   = t_r[s];
    end

    always_comb begin
      sh    = {rem_in, n_in[NW-1]};
      df    = sh - {2'b00, d_in};
      n_nxt = {n_in[NW-2:0], ~df[DW+1]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[s+1] <= n_nxt;
        t_r[s+1] <= t_in;
      end
    end

    // The remainder and divisor are only carried to stages that follow.
    if (s < NW-1) begin : g_keep
      logic [DW:0] rem_nxt;
      always_comb begin
        rem_nxt = df[DW+1] ? sh[DW:0] : df[DW:0];
      end
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s+1] <= rem_nxt;
          d_r[s+1]   <= d_in;
        end
      end
    end
  end

  assign quo     = n_r[NW];
  assign tag_out = t_r[NW];

endmodule

FILE: hdl/rbst_lane.sv
// ----------------------------------------------------------------------------
// rbst_lane: one axis slab evaluation
// Computes both slab distances with two pipelined dividers, saturates, orders.
// ----------------------------------------------------------------------------
module rbst_lane import rbst_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [COORD_W-1:0] org,
  input  logic signed [COORD_W-1:0] dir,
  input  logic signed [COORD_W-1:0] lo,
  input  logic signed [COORD_W-1:0] hi,
  input  logic [CFG_W-1:0]          zero_tol,
  output lane_res_t                 res
);

  logic signed [NUM_W-1:0] n0, n1;
  logic [COORD_W-1:0]      dmag;
  logic                    par, outs;
  logic [DIV_W-1:0]        a0, a1;
  logic                    s0, s1;
  logic [DIV_W-1:0]        q0, q1;
  logic [2:0]              tg0;
  logic                    tg1;

  // Operand setup: magnitudes and result signs. The magnitude of the most
  // negative direction is 2^31, which still fits the unsigned divisor.
  always_comb begin
    n0   = NUM_W'(lo) - NUM_W'(org);
    n1   = NUM_W'(hi) - NUM_W'(org);
    dmag = dir[COORD_W-1] ? COORD_W'(-dir) : COORD_W'(dir);
    par  = (dir == '0) || (dmag < COORD_W'(zero_tol));
    outs = (org < lo) || (org > hi);
    a0   = {(n0[NUM_W-1] ? NUM_W'(-n0) : NUM_W'(n0)), 16'd0};
    a1   = {(n1[NUM_W-1] ? NUM_W'(-n1) : NUM_W'(n1)), 16'd0};
    s0   = n0[NUM_W-1] ^ dir[COORD_W-1];
    s1   = n1[NUM_W-1] ^ dir[COORD_W-1];
  end

  rbst_div #(.TW(3)) u_div0 (.clk, .en, .num(a0), .den(dmag),
                             .tag_in({s0, par, outs}), .quo(q0), .tag_out(tg0));
  rbst_div #(.TW(1)) u_div1 (.clk, .en, .num(a1), .den(dmag),
                             .tag_in(s1), .quo(q1), .tag_out(tg1));

  // Sign, saturate and order the two distances.
  logic signed [COORD_W-1:0] t0, t1;
  function automatic logic signed [COORD_W-1:0] sat(input logic [QUO_W-1:0] m,
                                                    input logic neg);
    logic signed [COORD_W-1:0] r;
    if (neg) r = (m > QUO_W'(33'h8000_0000)) ? T_MIN : COORD_W'(-m);
    else     r = (m > QUO_W'(32'h7FFF_FFFF)) ? T_MAX : COORD_W'(m);
    return r;
  endfunction

  always_comb begin
    t0 = sat(q0, tg0[2]);
    t1 = sat(q1, tg1);
  end

  lane_res_t res_nxt;
  always_comb begin
    res_nxt.par  = tg0[1];
    res_nxt.out  = tg0[0];
    res_nxt.t_lo = (t0 > t1) ? t1 : t0;
    res_nxt.t_hi = (t0 > t1) ? t0 : t1;
  end

  always_ff @(posedge clk) begin
    if (en) res <= res_nxt;
  end

endmodule

FILE: hdl/ray_box_slab_test_core.sv
// ----------------------------------------------------------------------------
// ray_box_slab_test_core: streaming ray versus axis-aligned box test
// Three axis lanes with pipelined dividers feed a merge and decision stage.
// ----------------------------------------------------------------------------
// One ray/box pair is accepted every cycle while in_tready is high and one
// result leaves per pair. Each axis divider holds one quotient bit per stage
// (49 stages); an ordering stage and the merge/output register follow.
// All stages advance while the output register is empty or being drained.
module ray_box_slab_test_core import rbst_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // origin_x,y,z, dir_x,y,z, box_min_x,y,z, box_max_x,y,z
  input  logic [383:0]         in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // hit, t_near, t_far, zero padding
  output logic [71:0]          out_tdata,
  input  logic                 cfg_we,
  input  logic [IDX_W-1:0]     cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int LAT = DIV_W + 1;

  logic [CFG_W-1:0] zero_tol_r, min_t_r;
  logic [LAT-1:0]   vld_r;
  logic             en;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_tol_r <= CFG_W'(66);
      min_t_r    <= CFG_W'(66);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ZERO_TOL: zero_tol_r <= cfg_data;
        REG_MIN_T:    min_t_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  lane_res_t lres [NUM_AXES];
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    rbst_lane u_lane (
      .clk, .en,
      .org(in_tdata[a*32 +: 32]),
      .dir(in_tdata[(3+a)*32 +: 32]),
      .lo(in_tdata[(6+a)*32 +: 32]),
      .hi(in_tdata[(9+a)*32 +: 32]),
      .zero_tol(zero_tol_r),
      .res(lres[a])
    );
  end

  // Valid tracking along the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[LAT-2:0], in_tvalid};
  end

  // Merge the lanes and decide.
  logic signed [COORD_W-1:0] nr, fr, lim;
  logic                      ok, hit;
  logic [71:0]               od_nxt;
  always_comb begin
    nr = T_MIN;
    fr = T_MAX;
    ok = 1'b1;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (lres[a].par) begin
        if (lres[a].out) ok = 1'b0;
      end else begin
        if (lres[a].t_lo > nr) nr = lres[a].t_lo;
        if (lres[a].t_hi < fr) fr = lres[a].t_hi;
      end
    end
    lim    = COORD_W'(min_t_r);
    od_nxt = '0;
    hit    = 1'b0;
    if (ok) begin
      if (fr < lim) hit = 1'b0;
      else if (nr < lim) begin
        hit = 1'b1; od_nxt[32:1] = lim; od_nxt[64:33] = fr;
      end else if (nr > fr) hit = 1'b0;
      else begin
        hit = 1'b1; od_nxt[32:1] = nr; od_nxt[64:33] = fr;
      end
    end
    od_nxt[0] = hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (en) out_tvalid <= vld_r[LAT-1];
  end

  always_ff @(posedge clk) begin
    if (en) out_tdata <= od_nxt;
  end

endmodule
